FILE: rtl/core/ctc_pkg.sv
package ctc_pkg;

    localparam int unsigned MAX_CHUNK_DEF = 1024;

    localparam logic [2:0] EV_START   = 3'd0;
    localparam logic [2:0] EV_FETCH   = 3'd1;
    localparam logic [2:0] EV_ACK     = 3'd2;
    localparam logic [2:0] EV_CREQ    = 3'd3;
    localparam logic [2:0] EV_CHUNK   = 3'd4;
    localparam logic [2:0] EV_END     = 3'd5;
    localparam logic [2:0] EV_ABORT   = 3'd6;
    localparam logic [2:0] EV_LFETCH  = 3'd7;

    localparam logic [2:0] MK_NONE   = 3'd0;
    localparam logic [2:0] MK_ACK    = 3'd1;
    localparam logic [2:0] MK_REJECT = 3'd2;
    localparam logic [2:0] MK_REQ    = 3'd3;
    localparam logic [2:0] MK_SEND   = 3'd4;
    localparam logic [2:0] MK_ABORT  = 3'd5;
    localparam logic [2:0] MK_END    = 3'd6;
    localparam logic [2:0] MK_FETCH  = 3'd7;

    localparam logic [2:0] WE_NONE    = 3'd0;
    localparam logic [2:0] WE_BUSY    = 3'd1;
    localparam logic [2:0] WE_TOOBIG  = 3'd2;
    localparam logic [2:0] WE_UNSUP   = 3'd3;
    localparam logic [2:0] WE_INVSPEC = 3'd4;
    localparam logic [2:0] WE_WRFAIL  = 3'd5;

    localparam logic [3:0] RC_OK       = 4'd0;
    localparam logic [3:0] RC_BADMSG   = 4'd1;
    localparam logic [3:0] RC_REFUSED  = 4'd2;
    localparam logic [3:0] RC_CANCELED = 4'd3;
    localparam logic [3:0] RC_NODEV    = 4'd5;
    localparam logic [3:0] RC_EINVAL   = 4'd6;
    localparam logic [3:0] RC_OTHER    = 4'd7;
    localparam logic [3:0] RC_SENDFAIL = 4'd8;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WAIT  = 2'd1;
    localparam logic [1:0] PH_SERVE = 2'd2;
    localparam logic [1:0] PH_RECV  = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] peer_node;
        logic [31:0] transfer_tag;
        logic [31:0] seq_number;
        logic [31:0] size_total;
        logic [15:0] chunk_len;
        logic [31:0] byte_offset;
        logic        success_flag;
        logic [15:0] crc_value;
        logic [1:0]  endpoint_status;
        logic [1:0]  finish_status;
        logic        send_failed;
    } t_event;

    typedef struct packed {
        logic [2:0]  msg_kind;
        logic [63:0] dest_node;
        logic [31:0] msg_transfer;
        logic [31:0] msg_seq;
        logic [31:0] msg_offset;
        logic [15:0] msg_length;
        logic [31:0] msg_size;
        logic [15:0] msg_crc;
        logic        msg_success;
        logic [2:0]  msg_error;
        logic [3:0]  return_code;
        logic        last_of_run;
    } t_msg;

    typedef struct packed {
        logic [1:0]  phase;
        logic [63:0] peer_id;
        logic [31:0] xfer_id;
        logic [31:0] size;
        logic [31:0] rcvd;
        logic [15:0] blk_size;
        logic [15:0] crc;
    } t_xfer_state;

    function automatic logic [2:0] wire_err(input logic [1:0] st);
        case (st)
            2'd1:    return WE_UNSUP;
            2'd2:    return WE_INVSPEC;
            default: return WE_WRFAIL;
        endcase
    endfunction

    function automatic logic [3:0] ret_err(input logic [1:0] st);
        case (st)
            2'd1:    return RC_NODEV;
            2'd2:    return RC_EINVAL;
            default: return RC_OTHER;
        endcase
    endfunction

    function automatic t_msg msg_clear();
        return '0;
    endfunction

endpackage

FILE: rtl/core/ctc_decide.sv
// Event decode: next transfer state and up to two outgoing messages.
module ctc_decide
    import ctc_pkg::*;
#(
    parameter int unsigned MAX_CHUNK = MAX_CHUNK_DEF
) (
    input  t_event      i_ev,
    input  t_xfer_state i_st,
    output t_xfer_state o_st,
    output t_msg        o_m0,
    output t_msg        o_m1,
    output logic        o_two
);
    localparam logic [15:0] MAXC = 16'(MAX_CHUNK);

    logic        match;
    logic [31:0] rem;
    logic [31:0] newcnt;
    logic [31:0] left;
    logic [31:0] clen32;
    logic [3:0]  rc;
    logic        start_bad;

    assign match  = (i_ev.peer_node == i_st.peer_id) && (i_ev.transfer_tag == i_st.xfer_id);
    assign clen32 = {16'd0, i_ev.chunk_len};
    assign rem    = i_st.size - i_st.rcvd;
    assign newcnt = i_st.rcvd + clen32;
    assign left   = i_st.size - newcnt;
    assign start_bad = (i_ev.size_total == '0) || (i_ev.chunk_len == '0)
                       || (i_ev.chunk_len > MAXC);

    always_comb begin
        o_st  = i_st;
        o_m0  = msg_clear();
        o_m1  = msg_clear();
        o_two = 1'b0;
        rc    = RC_OK;
        unique case (i_ev.mode)
            EV_START: begin
                if (i_st.phase != PH_IDLE || start_bad || i_ev.endpoint_status != 2'd0) begin
                    o_m0.msg_kind  = MK_REJECT;
                    o_m0.msg_error = (i_st.phase != PH_IDLE) ? WE_BUSY :
                                     start_bad ? WE_TOOBIG : wire_err(i_ev.endpoint_status);
                    rc = i_ev.send_failed ? RC_SENDFAIL : RC_OK;
                end else begin
                    o_m0.msg_kind    = MK_ACK;
                    o_m0.msg_length  = i_ev.chunk_len;
                    o_m0.msg_size    = i_ev.size_total;
                    o_m0.msg_crc     = i_ev.crc_value;
                    o_m0.msg_success = 1'b1;
                    if (i_ev.send_failed) begin
                        o_st = '0;
                        rc   = RC_SENDFAIL;
                    end else begin
                        o_st.phase      = PH_RECV;
                        o_st.peer_id    = i_ev.peer_node;
                        o_st.xfer_id    = i_ev.transfer_tag;
                        o_st.size       = i_ev.size_total;
                        o_st.rcvd       = '0;
                        o_st.blk_size   = i_ev.chunk_len;
                        o_st.crc        = i_ev.crc_value;
                        o_two           = 1'b1;
                        o_m1.msg_kind   = MK_REQ;
                        o_m1.dest_node  = i_ev.peer_node;
                        o_m1.msg_transfer = i_ev.transfer_tag;
                        o_m1.msg_length = (i_ev.size_total < clen32) ?
                                          i_ev.size_total[15:0] : i_ev.chunk_len;
                    end
                end
                o_m0.dest_node    = i_ev.peer_node;
                o_m0.msg_transfer = i_ev.transfer_tag;
                o_m0.msg_seq      = i_ev.seq_number;
            end
            EV_FETCH: begin
                o_m0.dest_node    = i_ev.peer_node;
                o_m0.msg_transfer = i_ev.transfer_tag;
                o_m0.msg_seq      = i_ev.seq_number;
                if (i_st.phase != PH_IDLE || i_ev.endpoint_status != 2'd0
                    || i_ev.size_total == '0) begin
                    o_m0.msg_kind  = MK_REJECT;
                    o_m0.msg_error = (i_st.phase != PH_IDLE) ? WE_BUSY :
                                     (i_ev.endpoint_status != 2'd0) ?
                                     wire_err(i_ev.endpoint_status) : WE_INVSPEC;
                    rc = i_ev.send_failed ? RC_SENDFAIL : RC_OK;
                end else begin
                    o_m0.msg_kind    = MK_ACK;
                    o_m0.msg_length  = MAXC;
                    o_m0.msg_size    = i_ev.size_total;
                    o_m0.msg_crc     = i_ev.crc_value;
                    o_m0.msg_success = 1'b1;
                    if (i_ev.send_failed) begin
                        rc = RC_SENDFAIL;
                    end else begin
                        o_st.phase      = PH_SERVE;
                        o_st.peer_id    = i_ev.peer_node;
                        o_st.xfer_id    = i_ev.transfer_tag;
                        o_st.size       = i_ev.size_total;
                        o_st.rcvd       = '0;
                        o_st.blk_size   = MAXC;
                        o_st.crc        = i_ev.crc_value;
                    end
                end
            end
            EV_ACK: begin
                if (i_st.phase != PH_WAIT || !match) begin
                    rc = RC_BADMSG;
                end else if (!i_ev.success_flag) begin
                    o_st = '0;
                    rc   = RC_REFUSED;
                end else if (start_bad) begin
                    o_st = '0;
                    rc   = RC_BADMSG;
                end else if (i_ev.endpoint_status != 2'd0) begin
                    o_m0.msg_kind     = MK_ABORT;
                    o_m0.dest_node    = i_st.peer_id;
                    o_m0.msg_transfer = i_st.xfer_id;
                    o_m0.msg_error    = wire_err(i_ev.endpoint_status);
                    rc   = ret_err(i_ev.endpoint_status);
                    o_st = '0;
                end else begin
                    o_st.phase        = PH_RECV;
                    o_st.size         = i_ev.size_total;
                    o_st.crc          = i_ev.crc_value;
                    o_st.blk_size     = i_ev.chunk_len;
                    o_st.rcvd         = '0;
                    o_m0.msg_kind     = MK_REQ;
                    o_m0.dest_node    = i_st.peer_id;
                    o_m0.msg_transfer = i_st.xfer_id;
                    o_m0.msg_length   = (i_ev.size_total < clen32) ?
                                        i_ev.size_total[15:0] : i_ev.chunk_len;
                    rc = i_ev.send_failed ? RC_SENDFAIL : RC_OK;
                end
            end
            EV_CREQ: begin
                if (i_st.phase != PH_SERVE || !match || i_ev.chunk_len == '0
                    || i_ev.chunk_len > i_st.blk_size || i_ev.byte_offset >= i_st.size
                    || clen32 > (i_st.size - i_ev.byte_offset)) begin
                    rc = RC_BADMSG;
                end else if (i_ev.endpoint_status != 2'd0) begin
                    o_m0.msg_kind     = MK_ABORT;
                    o_m0.dest_node    = i_st.peer_id;
                    o_m0.msg_transfer = i_st.xfer_id;
                    o_m0.msg_error    = wire_err(i_ev.endpoint_status);
                    rc   = ret_err(i_ev.endpoint_status);
                    o_st = '0;
                end else begin
                    o_m0.msg_kind     = MK_SEND;
                    o_m0.dest_node    = i_st.peer_id;
                    o_m0.msg_transfer = i_st.xfer_id;
                    o_m0.msg_seq      = i_ev.seq_number;
                    o_m0.msg_offset   = i_ev.byte_offset;
                    o_m0.msg_length   = i_ev.chunk_len;
                    rc = i_ev.send_failed ? RC_SENDFAIL : RC_OK;
                end
            end
            EV_CHUNK: begin
                if (i_st.phase != PH_RECV || !match || i_ev.byte_offset != i_st.rcvd
                    || i_ev.chunk_len == '0 || i_ev.chunk_len > i_st.blk_size
                    || clen32 > rem) begin
                    rc = RC_BADMSG;
                end else if (i_ev.endpoint_status != 2'd0) begin
                    o_m0.msg_kind     = MK_ABORT;
                    o_m0.dest_node    = i_st.peer_id;
                    o_m0.msg_transfer = i_st.xfer_id;
                    o_m0.msg_error    = wire_err(i_ev.endpoint_status);
                    rc   = ret_err(i_ev.endpoint_status);
                    o_st = '0;
                end else if (newcnt == i_st.size) begin
                    o_m0.msg_kind     = MK_END;
                    o_m0.dest_node    = i_st.peer_id;
                    o_m0.msg_transfer = i_st.xfer_id;
                    o_m0.msg_size     = newcnt;
                    o_m0.msg_crc      = i_st.crc;
                    o_m0.msg_success  = (i_ev.finish_status == 2'd0);
                    o_m0.msg_error    = (i_ev.finish_status == 2'd0) ? WE_NONE :
                                        wire_err(i_ev.finish_status);
                    rc   = (i_ev.finish_status == 2'd0) ? RC_OK : ret_err(i_ev.finish_status);
                    o_st = '0;
                end else begin
                    o_st.rcvd         = newcnt;
                    o_m0.msg_kind     = MK_REQ;
                    o_m0.dest_node    = i_st.peer_id;
                    o_m0.msg_transfer = i_st.xfer_id;
                    o_m0.msg_offset   = newcnt;
                    o_m0.msg_length   = (left < {16'd0, i_st.blk_size}) ?
                                        left[15:0] : i_st.blk_size;
                    rc = i_ev.send_failed ? RC_SENDFAIL : RC_OK;
                end
            end
            EV_END: begin
                if (i_st.phase != PH_SERVE || !match) begin
                    rc = RC_BADMSG;
                end else begin
                    o_st = '0;
                    rc   = i_ev.success_flag ? RC_OK : RC_CANCELED;
                end
            end
            EV_ABORT: begin
                if (i_st.phase == PH_IDLE || !match) begin
                    rc = RC_BADMSG;
                end else begin
                    o_st = '0;
                    rc   = RC_CANCELED;
                end
            end
            default: begin
                if (i_st.phase != PH_IDLE) begin
                    rc = RC_EINVAL;
                end else begin
                    o_m0.msg_kind     = MK_FETCH;
                    o_m0.dest_node    = i_ev.peer_node;
                    o_m0.msg_transfer = i_ev.transfer_tag;
                    if (i_ev.send_failed) begin
                        rc = RC_SENDFAIL;
                    end else begin
                        o_st         = '0;
                        o_st.phase   = PH_WAIT;
                        o_st.peer_id = i_ev.peer_node;
                        o_st.xfer_id = i_ev.transfer_tag;
                    end
                end
            end
        endcase
        o_m0.return_code = rc;
        o_m1.return_code = rc;
        o_m0.last_of_run = !o_two;
        o_m1.last_of_run = 1'b1;
    end
endmodule

FILE: rtl/core/chunked_transfer_coordinator.sv
// Chunked transfer coordinator.
// Input channel: one transfer event per request (i_valid / o_stall, payload
// i_ev). Output channel: result messages (o_valid / i_stall, payload o_msg).
// Each event gives one or two results; last_of_run marks the final one.
// An event is registered, decoded combinationally, and its results land in a
// four-entry output queue. Throughput: one request per cycle for single-result
// events while o_stall is low; an event with two results (start accepted and
// its ACK sent) writes both to the queue, which hands them out one at a time.
// The decode uses the transfer state as updated by the previous event, so
// back-to-back events see a consistent state.
// When the receiver stalls, results wait in the queue; o_stall rises once
// the queue cannot take the results of the event still in the input
// register plus the worst case of two more.
// Reset (synchronous, active low) clears the transfer state to idle with
// all fields zero and empties both the input register and the queue.
module chunked_transfer_coordinator
    import ctc_pkg::*;
#(
    parameter int unsigned MAX_CHUNK = MAX_CHUNK_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_event i_ev,
    output logic   o_valid,
    input  logic   i_stall,
    output t_msg   o_msg
);
    t_event      r_ev;
    logic        r_ev_vld;
    t_xfer_state r_st;
    t_xfer_state n_st;
    t_msg        m0;
    t_msg        m1;
    logic        two;

    // result queue, four entries
    t_msg        r_q [4];
    logic [1:0]  r_rd;
    logic [1:0]  r_wr;
    logic [2:0]  r_cnt;
    logic        pop;
    logic        push;
    logic [2:0]  n_cnt;
    logic [2:0]  push_cnt;

    ctc_decide #(.MAX_CHUNK(MAX_CHUNK)) u_decide (
        .i_ev  (r_ev),
        .i_st  (r_st),
        .o_st  (n_st),
        .o_m0  (m0),
        .o_m1  (m1),
        .o_two (two)
    );

    // results the registered event adds at the next edge
    assign push_cnt = !r_ev_vld ? 3'd0 : (two ? 3'd2 : 3'd1);
    // keep room for those plus two from an event accepted now
    assign o_stall = (r_cnt + push_cnt) > 3'd2;
    assign push    = r_ev_vld;
    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_cnt != 3'd0);
    assign o_msg   = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt - {2'd0, pop};
        if (push) begin
            n_cnt = n_cnt + (two ? 3'd2 : 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_vld <= 1'b0;
            r_st     <= '0;
            r_rd     <= '0;
            r_wr     <= '0;
            r_cnt    <= '0;
        end else begin
            r_ev_vld <= i_valid && !o_stall;
            r_cnt    <= n_cnt;
            if (pop) begin
                r_rd <= r_rd + 2'd1;
            end
            if (push) begin
                r_st <= n_st;
                r_wr <= r_wr + (two ? 2'd2 : 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_ev <= i_ev;
        end
        if (push) begin
            r_q[r_wr] <= m0;
            if (two) begin
                r_q[r_wr + 2'd1] <= m1;
            end
        end
    end
endmodule
